[hw/rtl/srm_pkg.sv]
// Shared constants for the step response metrics block.
`default_nettype none
package srm_pkg;
    localparam int DIVISOR_W = 24;
    localparam int MAG_W = 23;
    localparam logic [MAG_W-1:0] MAG_MAX = 23'h7FFFFF;
    localparam logic [14:0] OVER_SCALE = 15'd25600;
    localparam logic [4:0] BAND_MUL = 5'd20;
    localparam logic [2:0] BAND_HOLD = 3'd5;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_BAND = 2'd1;
    localparam logic [1:0] PH_SETTLED = 2'd2;

    localparam logic [1:0] OP_OVER = 2'd0;
    localparam logic [1:0] OP_MEAN = 2'd1;
    localparam logic [1:0] OP_SQ = 2'd2;

    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;
endpackage
`default_nettype wire

[hw/rtl/srm_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module srm_div #(
    parameter int DW = 57
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire logic [DW-1:0]                  dividend,
    input  wire logic [srm_pkg::DIVISOR_W-1:0]  divisor,
    output logic                                busy,
    output logic [DW-1:0]                       quotient
);
    import srm_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [DW-1:0]        quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] div_reg;
    logic [DIVISOR_W:0]   rem_sh;
    logic                 ge;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DW-1]};
        ge = rem_sh >= {1'b0, div_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (load)
        begin
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[DW-2:0], ge};
            rem_next = ge ? DIVISOR_W'(rem_sh - {1'b0, div_reg}) : rem_sh[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (load)
            div_reg <= divisor;
    end

    assign busy = cnt_reg != '0;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

[hw/rtl/step_response_metrics.sv]
// Step response metrics: per-sample tracking and end-of-record statistics.
// A sample that is not marked last leaves the block idle, so it is ready again the next cycle.
// A last sample runs three divisions (two for a zero target) of 47+COUNT_BITS steps on one
// bit-serial divider before its result beat is registered; an empty record skips the divisions.
// Input stalls meanwhile and while the previous beat waits.
// Reset clears record state, sets target_speed to 0 and sample_limit to 50.
`default_nettype none
module step_response_metrics #(
    parameter int COUNT_BITS = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [23:0] sample,
    input  wire logic [31:0]        time_stamp,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [31:0]             rise_time,
    output logic [31:0]             peak_time,
    output logic [31:0]             settle_time,
    output logic signed [23:0]      overshoot_pct,
    output logic signed [23:0]      mean_speed,
    output logic signed [48:0]      variance,
    output logic                    rise_seen,
    output logic                    target_zero
);
    import srm_pkg::*;

    localparam int SUM_W = 24 + COUNT_BITS;
    localparam int SQ_W = 47 + COUNT_BITS;
    localparam int DW = SQ_W;
    localparam int LW = (COUNT_BITS > 10) ? COUNT_BITS : 10;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_DIV = 2'd2;
    localparam logic [1:0] S_FIN = 2'd3;

    logic signed [23:0]    target_speed_reg;
    logic [9:0]            sample_limit_reg;

    logic [1:0]            state_reg;
    logic [1:0]            op_reg;
    logic [1:0]            phase_reg;
    logic [MAG_W-1:0]      peak_reg;
    logic                  climbing_reg;
    logic [31:0]           first_reg, rise_reg, peak_stamp_reg, settle_reg;
    logic                  started_reg;
    logic [2:0]            band_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  neg_reg;
    logic signed [23:0]    over_reg, mean_reg;
    logic [47:0]           sqq_reg;
    logic [47:0]           msq_reg;
    logic                  out_valid_reg;

    logic                  accept, kept;
    logic                  out_free, fin_go;
    logic [MAG_W-1:0]      mag, tmag;
    logic [23:0]           texact;
    logic signed [24:0]    diff;
    logic [24:0]           diff_abs;
    logic [29:0]           band_lhs;
    logic                  in_band, rise_now;
    logic [1:0]            ph_a, ph_b;
    logic [2:0]            band_next;
    logic [47:0]           vsq;

    logic                  div_load, div_busy;
    logic [DW-1:0]         div_dividend, quotient;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic signed [MAG_W:0] over_num;
    logic [MAG_W-1:0]      over_abs;
    logic [SUM_W-1:0]      sum_abs;
    logic [47:0]           msq_next;

    function automatic logic [MAG_W-1:0] abs_sat(input logic signed [23:0] v);
        logic [23:0] m;
        m = v[23] ? 24'(-v) : 24'(v);
        return m[23] ? MAG_MAX : m[MAG_W-1:0];
    endfunction

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;
    assign kept = (LW'(count_reg) < LW'(sample_limit_reg)) && (count_reg != COUNT_MAX);
    // hold the final cycle until the output register is free
    assign out_free = !out_valid_reg || !out_stall;
    assign fin_go = (state_reg == S_FIN) && out_free;

    always_comb
    begin
        mag = abs_sat(sample);
        tmag = abs_sat(target_speed_reg);
        texact = target_speed_reg[23] ? 24'(-target_speed_reg) : 24'(target_speed_reg);
        rise_now = (phase_reg == PH_WAIT) && (tmag <= mag);
        ph_a = rise_now ? PH_BAND : phase_reg;
        diff = 25'(target_speed_reg) - 25'(sample);
        diff_abs = diff[24] ? 25'(-diff) : 25'(diff);
        band_lhs = 30'(diff_abs) * 30'(BAND_MUL);
        in_band = band_lhs < 30'(texact);
        band_next = in_band ? band_reg + 1'b1 : 3'd0;
        ph_b = ph_a;
        if (ph_a == PH_BAND && band_next > BAND_HOLD)
            ph_b = PH_SETTLED;
        vsq = 48'($unsigned(48'(sample) * 48'(sample)));
        over_num = $signed({1'b0, peak_reg}) - $signed({1'b0, tmag});
        over_abs = over_num[MAG_W] ? MAG_W'(-over_num) : over_num[MAG_W-1:0];
        sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        msq_next = 48'($unsigned(48'(mean_reg) * 48'(mean_reg)));
    end

    // divider sequencing
    always_comb
    begin
        div_load = 1'b0;
        div_dividend = '0;
        div_divisor = DIVISOR_W'(count_reg);
        if (state_reg == S_START && count_reg != '0)
        begin
            div_load = 1'b1;
            if (target_speed_reg != '0)
            begin
                div_dividend = DW'(38'(over_abs) * 38'(OVER_SCALE));
                div_divisor = DIVISOR_W'(tmag);
            end
            else
                div_dividend = DW'(sum_abs);
        end
        else if (state_reg == S_DIV && !div_busy && op_reg != OP_SQ)
        begin
            div_load = 1'b1;
            if (op_reg == OP_OVER)
                div_dividend = DW'(sum_abs);
            else
                div_dividend = DW'(sq_reg);
        end
    end

    srm_div #(.DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg <= '0;
            sample_limit_reg <= 10'd50;
            state_reg <= S_IDLE;
            op_reg <= OP_OVER;
            phase_reg <= PH_WAIT;
            peak_reg <= '0;
            climbing_reg <= 1'b1;
            first_reg <= '0;
            started_reg <= 1'b0;
            rise_reg <= '0;
            peak_stamp_reg <= '0;
            settle_reg <= '0;
            band_reg <= '0;
            sum_reg <= '0;
            sq_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET: target_speed_reg <= cfg_data;
                    CFG_LIMIT:  sample_limit_reg <= cfg_data[9:0];
                    default:    ;
                endcase
            end
            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (kept)
                        begin
                            if (!started_reg)
                            begin
                                first_reg <= time_stamp;
                                started_reg <= 1'b1;
                            end
                            if (rise_now)
                            begin
                                rise_reg <= time_stamp;
                                settle_reg <= time_stamp;
                            end
                            if (peak_reg <= mag)
                            begin
                                peak_reg <= mag;
                                if (climbing_reg)
                                    peak_stamp_reg <= time_stamp;
                            end
                            else if (climbing_reg && peak_reg >= tmag)
                                climbing_reg <= 1'b0;
                            if (ph_a == PH_BAND)
                            begin
                                band_reg <= band_next;
                                if (!in_band)
                                    settle_reg <= time_stamp;
                            end
                            phase_reg <= ph_b;
                            if (ph_b != PH_WAIT)
                            begin
                                sum_reg <= sum_reg + SUM_W'(sample);
                                sq_reg <= sq_reg + SQ_W'(vsq);
                            end
                            count_reg <= count_reg + 1'b1;
                        end
                        if (last)
                            state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    if (count_reg == '0)
                        state_reg <= S_FIN;
                    else
                    begin
                        state_reg <= S_DIV;
                        op_reg <= (target_speed_reg != '0) ? OP_OVER : OP_MEAN;
                    end
                end
                S_DIV:
                begin
                    if (!div_busy)
                    begin
                        case (op_reg)
                            OP_OVER: op_reg <= OP_MEAN;
                            OP_MEAN: op_reg <= OP_SQ;
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end
                default:
                begin
                    if (fin_go)
                    begin
                        state_reg <= S_IDLE;
                        phase_reg <= PH_WAIT;
                        peak_reg <= '0;
                        climbing_reg <= 1'b1;
                        first_reg <= '0;
                        started_reg <= 1'b0;
                        rise_reg <= '0;
                        peak_stamp_reg <= '0;
                        settle_reg <= '0;
                        band_reg <= '0;
                        sum_reg <= '0;
                        sq_reg <= '0;
                        count_reg <= '0;
                    end
                end
            endcase
        end
    end

    // result datapath
    always_ff @(posedge clk)
    begin
        msq_reg <= msq_next;
        if (state_reg == S_START)
        begin
            neg_reg <= (target_speed_reg == '0) ? sum_reg[SUM_W-1] : over_num[MAG_W];
            over_reg <= '0;
            mean_reg <= '0;
            sqq_reg <= '0;
        end
        if (state_reg == S_DIV && !div_busy)
        begin
            case (op_reg)
                OP_OVER:
                begin
                    if (!neg_reg)
                        over_reg <= (quotient > DW'(24'h7FFFFF)) ? 24'sh7FFFFF
                                                                : 24'(quotient);
                    else
                        over_reg <= (quotient > DW'(24'h800000)) ? 24'sh800000
                                                                : 24'(-quotient);
                    neg_reg <= sum_reg[SUM_W-1];
                end
                OP_MEAN:
                    mean_reg <= neg_reg ? 24'(-quotient) : 24'(quotient);
                default:
                    sqq_reg <= quotient[47:0];
            endcase
        end
        if (fin_go)
        begin
            rise_seen <= (phase_reg != PH_WAIT) && (count_reg != '0);
            target_zero <= target_speed_reg == '0;
            overshoot_pct <= over_reg;
            mean_speed <= mean_reg;
            if (count_reg != '0)
                variance <= 49'($signed({1'b0, sqq_reg}) - $signed({1'b0, msq_reg}));
            else
                variance <= '0;
            if (phase_reg != PH_WAIT && count_reg != '0)
            begin
                rise_time <= rise_reg - first_reg;
                peak_time <= peak_stamp_reg - first_reg;
                settle_time <= settle_reg - first_reg;
            end
            else
            begin
                rise_time <= '0;
                peak_time <= '0;
                settle_time <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

[tb/sv/step_response_metrics_checker.sv]
// Checker for step response metrics: watches both channels, predicts and compares results.
`default_nettype none
module step_response_metrics_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic signed [23:0] sample,
    input  wire logic [31:0]        time_stamp,
    input  wire logic               last,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [31:0]        rise_time,
    input  wire logic [31:0]        peak_time,
    input  wire logic [31:0]        settle_time,
    input  wire logic signed [23:0] overshoot_pct,
    input  wire logic signed [23:0] mean_speed,
    input  wire logic signed [48:0] variance,
    input  wire logic               rise_seen,
    input  wire logic               target_zero,
    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import srm_pkg::*;

    localparam longint COUNT_TOP = 1023;
    localparam longint S49_HI = 64'sd281474976710655;
    localparam longint S49_LO = -64'sd281474976710656;

    typedef struct packed {
        logic [31:0]        rise_t;
        logic [31:0]        peak_t;
        logic [31:0]        settle_t;
        logic signed [23:0] over;
        logic signed [23:0] mean;
        logic signed [48:0] var_v;
        logic               seen;
        logic               tzero;
    } metrics_t;

    metrics_t metrics_due[$];

    longint tgt;
    longint limit;
    logic [1:0] ph;
    longint peak_mag;
    bit climb;
    logic [31:0] t_first, t_rise, t_peak, t_settle;
    bit started;
    int band;
    longint sum_v, sum_sq, cnt;

    function automatic longint mag_sat(longint v);
        longint m;
        m = v < 0 ? -v : v;
        return m > 8388607 ? 8388607 : m;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic clear_record();
        ph = PH_WAIT;
        peak_mag = 0;
        climb = 1;
        t_first = 0;
        started = 0;
        t_rise = 0;
        t_peak = 0;
        t_settle = 0;
        band = 0;
        sum_v = 0;
        sum_sq = 0;
        cnt = 0;
    endtask

    task automatic absorb_sample(longint v, logic [31:0] t, bit fin);
        longint m, tm, te, d, n;
        metrics_t r;
        m = mag_sat(v);
        tm = mag_sat(tgt);
        te = tgt < 0 ? -tgt : tgt;
        if (cnt < limit && cnt < COUNT_TOP)
        begin
            if (!started)
            begin
                t_first = t;
                started = 1;
            end
            if (ph == PH_WAIT && tm <= m)
            begin
                t_rise = t;
                t_settle = t;
                ph = PH_BAND;
            end
            if (peak_mag <= m)
            begin
                peak_mag = m;
                if (climb)
                    t_peak = t;
            end
            else if (climb && peak_mag >= tm)
                climb = 0;
            if (ph == PH_BAND)
            begin
                d = tgt - v;
                if (d < 0)
                    d = -d;
                if (d * 20 < te)
                    band++;
                else
                begin
                    band = 0;
                    t_settle = t;
                end
                if (band > 5)
                    ph = PH_SETTLED;
            end
            if (ph != PH_WAIT)
            begin
                sum_v += v;
                sum_sq += v * v;
            end
            cnt++;
        end
        if (fin)
        begin
            r = '0;
            r.tzero = (tgt == 0);
            if (cnt > 0)
            begin
                n = cnt;
                if (tgt != 0)
                    r.over = 24'(clip(((peak_mag - tm) * 25600) / tm, -8388608, 8388607));
                d = clip(sum_v / n, -8388608, 8388607);
                r.mean = 24'(d);
                r.var_v = 49'(clip(sum_sq / n - d * d, S49_LO, S49_HI));
                r.seen = (ph != PH_WAIT);
                if (r.seen)
                begin
                    r.rise_t = t_rise - t_first;
                    r.peak_t = t_peak - t_first;
                    r.settle_t = t_settle - t_first;
                end
            end
            metrics_due = {metrics_due, r};
            clear_record();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        metrics_t e;
        if (!rst_n)
        begin
            tgt = 0;
            limit = 50;
            clear_record();
            metrics_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TARGET)
                    tgt = longint'($signed(cfg_data));
                else
                    limit = cfg_data[9:0];
            end
            if (in_valid && !in_stall)
                absorb_sample(longint'(sample), time_stamp, last);
            if (out_valid && !out_stall)
            begin
                if (metrics_due.size() == 0)
                begin
                    $error("unexpected result beat");
                    fail_count++;
                end
                else
                begin
                    e = metrics_due.pop_front();
                    if (rise_time !== e.rise_t)
                    begin
                        $error("rise_time exp %0d got %0d", e.rise_t, rise_time);
                        fail_count++;
                    end
                    if (peak_time !== e.peak_t)
                    begin
                        $error("peak_time exp %0d got %0d", e.peak_t, peak_time);
                        fail_count++;
                    end
                    if (settle_time !== e.settle_t)
                    begin
                        $error("settle_time exp %0d got %0d", e.settle_t, settle_time);
                        fail_count++;
                    end
                    if (overshoot_pct !== e.over)
                    begin
                        $error("overshoot_pct exp %0d got %0d", e.over, overshoot_pct);
                        fail_count++;
                    end
                    if (mean_speed !== e.mean)
                    begin
                        $error("mean_speed exp %0d got %0d", e.mean, mean_speed);
                        fail_count++;
                    end
                    if (variance !== e.var_v)
                    begin
                        $error("variance exp %0d got %0d", e.var_v, variance);
                        fail_count++;
                    end
                    if (rise_seen !== e.seen)
                    begin
                        $error("rise_seen exp %0d got %0d", e.seen, rise_seen);
                        fail_count++;
                    end
                    if (target_zero !== e.tzero)
                    begin
                        $error("target_zero exp %0d got %0d", e.tzero, target_zero);
                        fail_count++;
                    end
                end
            end
            pending = metrics_due.size();
        end
    end
endmodule
`default_nettype wire

[tb/sv/step_response_metrics_test.sv]
// Testbench top for step response metrics: stimulus, configuration phases and verdict.
`default_nettype none
module step_response_metrics_test;
    timeunit 1ns;
    timeprecision 1ps;
    import srm_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [23:0] cfg_data = '0;
    logic in_valid = 0;
    logic signed [23:0] sample = '0;
    logic [31:0] time_stamp = '0;
    logic last = 0;
    logic out_stall = 0;
    logic in_stall, out_valid, rise_seen, target_zero;
    logic [31:0] rise_time, peak_time, settle_time;
    logic signed [23:0] overshoot_pct, mean_speed;
    logic signed [48:0] variance;
    int fail_count, pending;

    int target_now;
    logic [31:0] clock_us;
    int stall_mode;

    always #6 clk = ~clk;

    step_response_metrics dut (.*);
    step_response_metrics_checker chk (.*);

    task automatic write_reg(logic idx, logic [23:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Present one beat and hold it until accepted.
    task automatic send_beat(logic signed [23:0] v, logic [31:0] t, logic fin);
        sample <= v;
        time_stamp <= t;
        last <= fin;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic gap_maybe();
        int g;
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            g = $urandom_range(1, 4);
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    // Step-like record: each sample is a ramp, overshoot, near-target or random value, chosen at random.
    task automatic step_record(int len);
        int i, v;
        longint tg;
        tg = target_now;
        for (i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0: v = $urandom;
                1, 2: v = int'(tg * i / (len > 1 ? len : 1));
                3: v = int'(tg + tg / 8);
                default: v = int'(tg + (tg / 64) * ($signed($urandom_range(0, 4)) - 2));
            endcase
            if (i < 3 && $urandom_range(0, 1))
                v = int'(tg * i / 3);
            clock_us += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 2000);
            send_beat(v[23:0], clock_us, i == len - 1);
            gap_maybe();
        end
    endtask

    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    initial
    begin
        int k, lens;
        stall_mode = 0;
        target_now = 0;
        clock_us = 32'hFFFF_FF00;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Default settings: zero target, extremes of sample, a single-sample record.
        send_beat(24'sh7FFFFF, 32'hFFFFFFFF, 0);
        send_beat(-24'sh800000, 32'h0, 1);
        send_beat(24'sh0, 32'h5, 1);
        drain();
        target_now = -24'sh800000;
        write_reg(CFG_TARGET, target_now[23:0]);
        write_reg(CFG_LIMIT, 10'd1023);
        send_beat(-24'sh800000, 32'hFFFF_FFF0, 0);
        send_beat(24'sh7FFFFF, 32'h10, 0);
        send_beat(-24'sh7FFFF0, 32'h20, 1);
        drain();
        target_now = 24'sh10000;
        write_reg(CFG_TARGET, target_now[23:0]);
        write_reg(CFG_LIMIT, 10'd1);
        send_beat(24'sh8000, 32'd100, 0);
        send_beat(24'sh20000, 32'd200, 1);
        drain();
        write_reg(CFG_LIMIT, 10'd0);
        send_beat(24'sh20000, 32'd300, 1);
        drain();
        write_reg(CFG_LIMIT, 10'd50);
        step_record(12);
        send_beat(24'sh100, 32'd7, 1);
        drain();
        for (k = 0; k < 12; k++)
        begin
            stall_mode = k % 3;
            case (k % 4)
                0: target_now = $signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8;
                1: target_now = $urandom_range(1, 24'h40000);
                2: target_now = -$urandom_range(1, 24'h40000);
                default: target_now = (k == 3) ? 24'sh7FFFFF : 24'sh0;
            endcase
            write_reg(CFG_TARGET, target_now[23:0]);
            write_reg(CFG_LIMIT,
                      24'((k == 5) ? 10'd1023 : (k == 7 ? 10'd3 : $urandom_range(8, 60))));
            repeat (4)
            begin
                lens = $urandom_range(1, 25);
                step_record(lens);
            end
            drain();
        end
        if (fail_count == 0)
            $display("step_response_metrics_test: done, clean");
        else
            $display("step_response_metrics_test: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("step_response_metrics_test: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

[step_response_metrics.f]
hw/rtl/srm_pkg.sv
hw/rtl/srm_div.sv
hw/rtl/step_response_metrics.sv
tb/sv/step_response_metrics_checker.sv
tb/sv/step_response_metrics_test.sv
